[rtl/core/mrce_pkg.sv]
// ----------------------------------------------------------------------------
// mrce_pkg
// Shared types and constants of the mini RISC execute core: opcodes,
// transaction payloads and memory geometry.
// ----------------------------------------------------------------------------
package mrce_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int REG_COUNT = 32;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int DATA_W    = 32;
    localparam int PC_W      = 12;
    localparam int RIDX_W    = 5;
    localparam int OP_W      = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_ADDI = 4'd2,
        OP_BNE  = 4'd3,
        OP_BLT  = 4'd4,
        OP_LW   = 4'd5,
        OP_SW   = 4'd6,
        OP_BEQ  = 4'd7,
        OP_J    = 4'd8,
        OP_JAL  = 4'd9,
        OP_LA   = 4'd10,
        OP_LI   = 4'd11,
        OP_NOP  = 4'd12
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [RIDX_W-1:0]        dest_reg;
        logic [RIDX_W-1:0]        src_a;
        logic [RIDX_W-1:0]        src_b;
        logic signed [DATA_W-1:0] immediate;
        logic [PC_W-1:0]          target_address;
    } t_in_item;

    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic                     reg_written;
        logic [RIDX_W-1:0]        write_index;
        logic signed [DATA_W-1:0] write_value;
        logic                     mem_written;
        logic                     addr_fault;
    } t_out_item;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              wr;
        logic              is_load;
        logic [RIDX_W-1:0] rd;
        logic [DATA_W-1:0] val;
        logic              mw;
        logic              fault;
    } t_s2_item;

endpackage

[rtl/core/mini_risc_core_execute_core.sv]
// ----------------------------------------------------------------------------
// mini_risc_core_execute_core
// Executes one pre-decoded instruction per transaction against a register
// file, a program counter and a word data memory with valid marks.
// ----------------------------------------------------------------------------
// path: input -> stage 1 -> stage 2 -> output register
// throughput: one instruction per cycle unless stalled, set by the register
//   file reads in stage 1 and the data memory read/write at the stage 1 exit
// reset: synchronous, active low; pc and register file read as zero, then
//   a clearing pass clears the data memory valid marks, input is stalled
// ----------------------------------------------------------------------------
module mini_risc_core_execute_core
    import mrce_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  t_in_item        i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output t_out_item       o_out_data,
    input  logic            i_out_stall,
    input  logic            i_cfg_valid,
    input  logic [PC_W-1:0] i_cfg_data,
    output logic            o_cfg_ready
);

    function automatic logic f_in_range(input logic [RIDX_W-1:0] idx);
        return 32'(idx) < 32'(REG_COUNT);
    endfunction

    function automatic logic [DATA_W-1:0] f_fwd(
        input logic [RIDX_W-1:0] idx,
        input logic [DATA_W-1:0] ram_val,
        input logic              ram_ok,
        input logic              s2_hit,
        input logic [RIDX_W-1:0] s2_rd,
        input logic [DATA_W-1:0] s2_val,
        input logic              lwb_hit,
        input logic [RIDX_W-1:0] lwb_rd,
        input logic [DATA_W-1:0] lwb_val
    );
        logic [DATA_W-1:0] v;
        if (!f_in_range(idx)) begin
            v = '0;
        end else if (s2_hit && s2_rd == idx) begin
            v = s2_val;
        end else if (lwb_hit && lwb_rd == idx) begin
            v = lwb_val;
        end else if (ram_ok) begin
            v = ram_val;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    logic              r_s1_valid;
    t_in_item          r_s1;
    logic              r_s2_valid;
    t_s2_item          r_s2;
    t_s2_item          n_s2;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [PC_W-1:0]   r_pc;
    logic [REG_COUNT-1:0] r_rf_valid;
    logic              r_lwb_valid;
    logic [RIDX_W-1:0] r_lwb_rd;
    logic [DATA_W-1:0] r_lwb_val;
    logic              r_clearing;
    logic [MEM_AW-1:0] r_clr_idx;

    logic out_adv, s2_adv, s2_free, s1_adv, s1_free, accept;
    logic [DATA_W-1:0] rf_a_q, rf_b_q, rf_d_q;
    logic [DATA_W:0]   dm_rdata;
    logic              s2_wr;
    logic [DATA_W-1:0] s2_val;
    logic              rf_we;
    logic [DATA_W-1:0] val_a, val_b, val_d, addr;
    logic              addr_bad;
    logic [PC_W:0]     pc_inc;
    logic              dm_re, dm_we;
    logic [MEM_AW-1:0] dm_waddr;
    logic [DATA_W:0]   dm_wdata;

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign s2_adv     = r_s2_valid && out_adv;
    assign s2_free    = !r_s2_valid || out_adv;
    assign s1_adv     = r_s1_valid && s2_free;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_stall = !s1_free || r_clearing;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // register file, one copy per read port
    mrce_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2.rd[REG_AW-1:0]),
        .i_wdata (s2_val),
        .i_re    (accept),
        .i_raddr (i_in_data.src_a[REG_AW-1:0]),
        .o_rdata (rf_a_q)
    );

    mrce_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2.rd[REG_AW-1:0]),
        .i_wdata (s2_val),
        .i_re    (accept),
        .i_raddr (i_in_data.src_b[REG_AW-1:0]),
        .o_rdata (rf_b_q)
    );

    mrce_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_d (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2.rd[REG_AW-1:0]),
        .i_wdata (s2_val),
        .i_re    (accept),
        .i_raddr (i_in_data.dest_reg[REG_AW-1:0]),
        .o_rdata (rf_d_q)
    );

    // data memory, valid mark in the top bit
    mrce_ram #(.WIDTH(DATA_W + 1), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (addr[MEM_AW-1:0]),
        .o_rdata (dm_rdata)
    );

    assign s2_wr  = r_s2.is_load ? dm_rdata[DATA_W] : r_s2.wr;
    assign s2_val = r_s2.is_load ? dm_rdata[DATA_W-1:0] : r_s2.val;
    assign rf_we  = s2_adv && s2_wr;

    always_comb begin
        val_a = f_fwd(r_s1.src_a, rf_a_q, r_rf_valid[r_s1.src_a[REG_AW-1:0]],
                      r_s2_valid && s2_wr, r_s2.rd, s2_val,
                      r_lwb_valid, r_lwb_rd, r_lwb_val);
        val_b = f_fwd(r_s1.src_b, rf_b_q, r_rf_valid[r_s1.src_b[REG_AW-1:0]],
                      r_s2_valid && s2_wr, r_s2.rd, s2_val,
                      r_lwb_valid, r_lwb_rd, r_lwb_val);
        val_d = f_fwd(r_s1.dest_reg, rf_d_q, r_rf_valid[r_s1.dest_reg[REG_AW-1:0]],
                      r_s2_valid && s2_wr, r_s2.rd, s2_val,
                      r_lwb_valid, r_lwb_rd, r_lwb_val);
    end

    assign addr     = val_a + DATA_W'(r_s1.immediate);
    assign addr_bad = addr[DATA_W-1] || (addr >= DATA_W'(MEM_WORDS));
    assign pc_inc   = {1'b0, r_pc} + (PC_W + 1)'(1);

    always_comb begin
        n_s2         = '0;
        n_s2.next_pc = pc_inc[PC_W-1:0];
        n_s2.rd      = r_s1.dest_reg;
        unique case (r_s1.op)
            OP_ADD: begin
                n_s2.wr  = 1'b1;
                n_s2.val = val_a + val_b;
            end
            OP_SUB: begin
                n_s2.wr  = 1'b1;
                n_s2.val = val_a - val_b;
            end
            OP_ADDI: begin
                n_s2.wr  = 1'b1;
                n_s2.val = addr;
            end
            OP_BNE: begin
                if (val_d != val_a) n_s2.next_pc = r_s1.target_address;
            end
            OP_BLT: begin
                if ($signed(val_d) < $signed(val_a)) n_s2.next_pc = r_s1.target_address;
            end
            OP_LW: begin
                n_s2.fault   = addr_bad;
                n_s2.is_load = !addr_bad && f_in_range(r_s1.dest_reg);
            end
            OP_SW: begin
                n_s2.fault = addr_bad;
                n_s2.mw    = !addr_bad;
            end
            OP_BEQ: begin
                if (val_d == val_a) n_s2.next_pc = r_s1.target_address;
            end
            OP_J: begin
                n_s2.next_pc = r_s1.target_address;
            end
            OP_JAL: begin
                n_s2.wr      = 1'b1;
                n_s2.val     = DATA_W'(pc_inc);
                n_s2.next_pc = r_s1.target_address;
            end
            OP_LA: begin
                n_s2.wr  = 1'b1;
                n_s2.val = DATA_W'(r_s1.target_address);
            end
            OP_LI: begin
                n_s2.wr  = 1'b1;
                n_s2.val = r_s1.immediate;
            end
            default: begin
            end
        endcase
        n_s2.wr = n_s2.wr && f_in_range(r_s1.dest_reg);
    end

    assign dm_re    = s1_adv && n_s2.is_load;
    assign dm_we    = r_clearing || (s1_adv && n_s2.mw);
    assign dm_waddr = r_clearing ? r_clr_idx : addr[MEM_AW-1:0];
    assign dm_wdata = r_clearing ? '0 : {1'b1, val_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_rf_valid  <= '0;
            r_lwb_valid <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
        end else begin
            if (s1_free) r_s1_valid <= accept;
            if (s2_free) r_s2_valid <= r_s1_valid;
            if (out_adv) r_out_valid <= r_s2_valid;
            if (i_cfg_valid) begin
                r_pc <= i_cfg_data;
            end else if (s1_adv) begin
                r_pc <= n_s2.next_pc;
            end
            if (rf_we) begin
                r_rf_valid[r_s2.rd[REG_AW-1:0]] <= 1'b1;
                r_lwb_valid <= 1'b1;
            end
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + MEM_AW'(1);
                if (r_clr_idx == MEM_AW'(MEM_WORDS - 1)) r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_s1 <= i_in_data;
        if (s1_adv) r_s2 <= n_s2;
        if (rf_we) begin
            r_lwb_rd  <= r_s2.rd;
            r_lwb_val <= s2_val;
        end
        if (s2_adv) begin
            r_out.next_pc     <= r_s2.next_pc;
            r_out.reg_written <= s2_wr;
            r_out.write_index <= s2_wr ? r_s2.rd : '0;
            r_out.write_value <= s2_wr ? s2_val : '0;
            r_out.mem_written <= r_s2.mw;
            r_out.addr_fault  <= r_s2.fault;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/core/mrce_ram.sv]
// ----------------------------------------------------------------------------
// mrce_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mrce_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mrce_checker.sv]
// ----------------------------------------------------------------------------
// mrce_checker
// Port-level checks of the mini RISC execute core, bound to the top level.
// ----------------------------------------------------------------------------
module mrce_checker
    import mrce_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_in_stall,
    input  logic            o_out_valid,
    input  t_out_item       o_out_data,
    input  logic            i_out_stall
);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    a_no_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.reg_written
            |-> o_out_data.write_index == '0 && o_out_data.write_value == '0)
        else $error("write fields set without register write");

    a_store_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.mem_written &&
                          (o_out_data.addr_fault || o_out_data.reg_written)))
        else $error("store flagged together with fault or register write");

    // clearing pass blocks input right after reset
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("input accepted or output valid right after reset");

endmodule

bind mini_risc_core_execute_core mrce_checker u_mrce_checker (.*);
